>>> rtl/core/cts_pkg.sv
// Shared constants and the arctangent table for the cartesian-to-spherical core.
// No dependencies; imported by cts_cordic, cts_gain and cartesian_to_spherical.
`timescale 1ns / 1ps

package cts_pkg;

  // Coordinates are scaled up by 2^GUARD_BITS ahead of the CORDIC passes
  localparam int GUARD_BITS = 4;

  // 1/K of the CORDIC gain, Q24
  localparam int INV_GAIN_W    = 24;
  localparam int INV_GAIN_FRAC = 24;
  localparam logic [INV_GAIN_W-1:0] INV_GAIN_Q24 = 24'd10188014;

  // Angle accumulator: signed turns, 32 fraction bits, two integer bits of headroom
  localparam int TURN_W = 32;
  localparam int ANG_W  = TURN_W + 2;
  localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(64'd1 << (TURN_W - 1));

  // round(atan(2^-i) / (2*pi) * 2^32)
  function automatic logic [TURN_W-1:0] atan_turns(input logic [4:0] idx);
    logic [TURN_W-1:0] val;
    case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051E;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2F;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2FA;
      5'd15:   val = 32'h0000517D;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A30;
      5'd19:   val = 32'h00000518;
      5'd20:   val = 32'h0000028C;
      5'd21:   val = 32'h00000146;
      5'd22:   val = 32'h000000A3;
      5'd23:   val = 32'h00000051;
      5'd24:   val = 32'h00000029;
      5'd25:   val = 32'h00000014;
      5'd26:   val = 32'h0000000A;
      5'd27:   val = 32'h00000005;
      5'd28:   val = 32'h00000003;
      5'd29:   val = 32'h00000001;
      5'd30:   val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/core/cartesian_to_spherical.sv
// Cartesian-to-spherical converter: two pipelined CORDIC vectoring passes
// with gain correction. Depends on cts_pkg, cts_cordic and cts_gain.
//
// One (x, y, z) word enters per clock and one (radius, polar_angle, azimuth)
// word leaves per clock, in order. The pipeline has one input stage,
// CORDIC_STAGES micro-rotations for the xy plane, two gain-correction
// stages, one pass-two setup stage, CORDIC_STAGES micro-rotations for the
// (z, rho) plane, two more gain stages, one output formatting stage and
// the output register. The output register is backed by a one-word skid
// buffer, so s_axis_tready_o comes from a flop and input keeps flowing
// while one finished word waits downstream; the pipeline holds when the
// skid buffer is occupied. Radius is on the input scale, polar_angle in
// units of pi/2^(ANGLE_WIDTH-1), azimuth in units of 2*pi/2^ANGLE_WIDTH.
`timescale 1ns / 1ps

module cartesian_to_spherical import cts_pkg::*; #(
  parameter int COORD_WIDTH   = 16,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: x_coord, y_coord, z_coord (COORD_WIDTH each, signed), zero pad
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: radius (COORD_WIDTH), polar_angle, azimuth (ANGLE_WIDTH each), zero pad
  output logic [((COORD_WIDTH+2*ANGLE_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                                           m_axis_tvalid_o,
  input  logic                                           m_axis_tready_i
);

  localparam int CW       = COORD_WIDTH;
  localparam int AW       = ANGLE_WIDTH;
  localparam int NUM_ITER = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int DW       = CW + GUARD_BITS + 3;   // signed CORDIC datapath
  localparam int MW       = DW - 1;                // corrected magnitude
  localparam int OUT_W    = ((CW + 2*AW + 7) / 8) * 8;
  localparam int RES_W    = CW + 2*AW;
  localparam int SB1_W    = CW + 1;                // {zero_xy, z}
  localparam int SB2_W    = CW + 1 + TURN_W;       // {zero_xy, z, theta turns}
  localparam int RND_W    = MW + 1 - GUARD_BITS;

  // Map turns (32 fraction bits) to output units, rounding half up
  function automatic logic [AW-1:0] to_units(input logic [TURN_W-1:0] t);
    logic [TURN_W+1:0] v;
    v = {1'b0, t, 1'b0} + ((TURN_W+2)'(1) << (TURN_W - AW));
    return v[TURN_W+1-AW +: AW];
  endfunction

  logic adv;

  // ---------------------------------------------------------------------------
  // Input stage: scale, pre-rotate by pi when x < 0, flag x = y = 0
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] x_in, y_in, z_in;
  logic signed [DW-1:0] x_sc, y_sc;
  logic                 in_vld_q;
  logic signed [DW-1:0] p1_x_q, p1_y_q;
  logic signed [ANG_W-1:0] p1_ang_q;
  logic [SB1_W-1:0]     p1_sb_q;

  assign x_in = s_axis_tdata_i[CW-1:0];
  assign y_in = s_axis_tdata_i[2*CW-1:CW];
  assign z_in = s_axis_tdata_i[3*CW-1:2*CW];
  assign x_sc = DW'(x_in) <<< GUARD_BITS;
  assign y_sc = DW'(y_in) <<< GUARD_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_x_q   <= x_in[CW-1] ? -x_sc : x_sc;
      p1_y_q   <= x_in[CW-1] ? -y_sc : y_sc;
      p1_ang_q <= x_in[CW-1] ? HALF_TURN : '0;
      p1_sb_q  <= {(x_in == '0) && (y_in == '0), z_in};
    end
  end

  // ---------------------------------------------------------------------------
  // Pass one: (x, y) -> rho, theta
  // ---------------------------------------------------------------------------
  logic                    c1_vld;
  logic signed [DW-1:0]    c1_x;
  logic signed [ANG_W-1:0] c1_ang;
  logic [SB2_W-1:0]        c1_sb;
  logic                    g1_vld;
  logic [MW-1:0]           g1_mag;
  logic [SB2_W-1:0]        g1_sb;

  cts_cordic #(.DATA_W(DW), .STAGES(NUM_ITER), .SB_W(SB1_W)) u_pass1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (in_vld_q),
    .x_i    (p1_x_q),
    .y_i    (p1_y_q),
    .ang_i  (p1_ang_q),
    .sb_i   (p1_sb_q),
    .vld_o  (c1_vld),
    .x_o    (c1_x),
    .ang_o  (c1_ang),
    .sb_o   (c1_sb[SB2_W-1:TURN_W])
  );

  // Theta only needs its turn fraction from here on
  assign c1_sb[TURN_W-1:0] = c1_ang[TURN_W-1:0];

  cts_gain #(.IN_W(DW), .SB_W(SB2_W)) u_gain1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (c1_vld),
    .mag_i  (c1_x),
    .sb_i   (c1_sb),
    .vld_o  (g1_vld),
    .mag_o  (g1_mag),
    .sb_o   (g1_sb)
  );

  // ---------------------------------------------------------------------------
  // Pass two setup: (z, rho), pre-rotated by pi when z < 0
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0]    g1_z;
  logic signed [DW-1:0]    z_sc, rho;
  logic                    p2_vld_q;
  logic signed [DW-1:0]    p2_x_q, p2_y_q;
  logic signed [ANG_W-1:0] p2_ang_q;
  logic [SB2_W-1:0]        p2_sb_q;

  assign g1_z = g1_sb[TURN_W +: CW];
  assign z_sc = DW'(g1_z) <<< GUARD_BITS;
  assign rho  = DW'(g1_mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (adv) begin
      p2_vld_q <= g1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_x_q   <= g1_z[CW-1] ? -z_sc : z_sc;
      p2_y_q   <= g1_z[CW-1] ? -rho : rho;
      p2_ang_q <= g1_z[CW-1] ? HALF_TURN : '0;
      p2_sb_q  <= g1_sb;
    end
  end

  // ---------------------------------------------------------------------------
  // Pass two: (z, rho) -> r, phi
  // ---------------------------------------------------------------------------
  logic                    c2_vld;
  logic signed [DW-1:0]    c2_x;
  logic signed [ANG_W-1:0] c2_ang;
  logic [SB2_W-1:0]        c2_sb;
  logic                    g2_vld;
  logic [MW-1:0]           g2_mag;
  logic [SB2_W+ANG_W-1:0]  g2_sb;

  cts_cordic #(.DATA_W(DW), .STAGES(NUM_ITER), .SB_W(SB2_W)) u_pass2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (p2_vld_q),
    .x_i    (p2_x_q),
    .y_i    (p2_y_q),
    .ang_i  (p2_ang_q),
    .sb_i   (p2_sb_q),
    .vld_o  (c2_vld),
    .x_o    (c2_x),
    .ang_o  (c2_ang),
    .sb_o   (c2_sb)
  );

  cts_gain #(.IN_W(DW), .SB_W(SB2_W+ANG_W)) u_gain2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (c2_vld),
    .mag_i  (c2_x),
    .sb_i   ({c2_sb, c2_ang}),
    .vld_o  (g2_vld),
    .mag_o  (g2_mag),
    .sb_o   (g2_sb)
  );

  // ---------------------------------------------------------------------------
  // Output formatting: drop guard bits, saturate, clamp phi, map angles
  // ---------------------------------------------------------------------------
  logic signed [ANG_W-1:0] phi_turns;
  logic [TURN_W-1:0]       theta_turns, phi_t;
  logic                    zero_xy;
  logic signed [CW-1:0]    fz;
  logic [MW:0]             r_sum;
  logic [RND_W-1:0]        r_rnd;
  logic [CW-1:0]           radius_d;
  logic [AW-1:0]           phi_d, theta_d;
  logic                    fin_vld_q;
  logic [RES_W-1:0]        fin_q;

  assign phi_turns   = g2_sb[ANG_W-1:0];
  assign theta_turns = g2_sb[ANG_W +: TURN_W];
  assign fz          = g2_sb[ANG_W+TURN_W +: CW];
  assign zero_xy     = g2_sb[SB2_W+ANG_W-1];

  assign r_sum = (MW+1)'(g2_mag) + ((MW+1)'(1) << (GUARD_BITS - 1));
  assign r_rnd = r_sum[MW:GUARD_BITS];

  always_comb begin
    // Polar residue clamped to [0, half turn]
    if (phi_turns[ANG_W-1]) begin
      phi_t = '0;
    end else if (phi_turns > HALF_TURN) begin
      phi_t = HALF_TURN[TURN_W-1:0];
    end else begin
      phi_t = phi_turns[TURN_W-1:0];
    end

    if (zero_xy) begin
      // On the z axis: exact |z|, phi is 0 or pi, no azimuth
      radius_d = fz[CW-1] ? CW'(-fz) : CW'(fz);
      phi_d    = fz[CW-1] ? (AW'(1) << (AW - 1)) : '0;
      theta_d  = '0;
    end else begin
      radius_d = (r_rnd[RND_W-1:CW] != '0) ? '1 : r_rnd[CW-1:0];
      phi_d    = to_units(phi_t);
      theta_d  = to_units(theta_turns);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else if (adv) begin
      fin_vld_q <= g2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fin_q <= {theta_d, phi_d, radius_d};
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with one-word skid buffer; the pipeline holds while the
  // skid buffer is occupied
  // ---------------------------------------------------------------------------
  logic             out_vld_q, out_vld_d;
  logic             skid_vld_q, skid_vld_d;
  logic [RES_W-1:0] out_q, skid_q;
  logic             out_free, take_fin;

  assign adv      = !skid_vld_q;
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign take_fin = adv && fin_vld_q;

  always_comb begin
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    skid_vld_d = skid_vld_q;
    if (skid_vld_q && m_axis_tready_i) begin
      out_vld_d  = 1'b1;
      skid_vld_d = 1'b0;
    end else if (take_fin) begin
      if (out_free) begin
        out_vld_d = 1'b1;
      end else begin
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q && m_axis_tready_i) begin
      out_q <= skid_q;
    end else if (take_fin && out_free) begin
      out_q <= fin_q;
    end
    if (take_fin && !out_free) begin
      skid_q <= fin_q;
    end
  end

  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_W'(out_q);

endmodule

>>> rtl/core/cts_cordic.sv
// Pipelined CORDIC vectoring pass, one micro-rotation per register stage.
// Uses cts_pkg for the arctangent table and the angle accumulator width.
`timescale 1ns / 1ps

module cts_cordic import cts_pkg::*; #(
  parameter int DATA_W = 23,
  parameter int STAGES = 16,
  parameter int SB_W   = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic signed [DATA_W-1:0] x_i,
  input  logic signed [DATA_W-1:0] y_i,
  input  logic signed [ANG_W-1:0]  ang_i,
  input  logic [SB_W-1:0]          sb_i,
  output logic                     vld_o,
  output logic signed [DATA_W-1:0] x_o,
  output logic signed [ANG_W-1:0]  ang_o,
  output logic [SB_W-1:0]          sb_o
);

  // Stage taps: index 0 is the input, index k+1 the output of stage k
  logic                     vld_w [STAGES+1];
  logic signed [DATA_W-1:0] x_w   [STAGES+1];
  logic signed [DATA_W-1:0] y_w   [STAGES+1];
  logic signed [ANG_W-1:0]  ang_w [STAGES+1];
  logic [SB_W-1:0]          sb_w  [STAGES+1];

  assign vld_w[0] = vld_i;
  assign x_w[0]   = x_i;
  assign y_w[0]   = y_i;
  assign ang_w[0] = ang_i;
  assign sb_w[0]  = sb_i;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic signed [ANG_W-1:0] ATAN_K = ANG_W'(atan_turns(5'(k)));

    logic                     vld_q;
    logic signed [DATA_W-1:0] x_d, x_q, y_d, y_q;
    logic signed [ANG_W-1:0]  ang_d, ang_q;
    logic [SB_W-1:0]          sb_q;

    // Rotate toward y = 0; y >= 0 counts as positive
    always_comb begin
      if (!y_w[k][DATA_W-1]) begin
        x_d   = x_w[k] + (y_w[k] >>> k);
        y_d   = y_w[k] - (x_w[k] >>> k);
        ang_d = ang_w[k] + ATAN_K;
      end else begin
        x_d   = x_w[k] - (y_w[k] >>> k);
        y_d   = y_w[k] + (x_w[k] >>> k);
        ang_d = ang_w[k] - ATAN_K;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q   <= x_d;
        y_q   <= y_d;
        ang_q <= ang_d;
        sb_q  <= sb_w[k];
      end
    end

    assign vld_w[k+1] = vld_q;
    assign x_w[k+1]   = x_q;
    assign y_w[k+1]   = y_q;
    assign ang_w[k+1] = ang_q;
    assign sb_w[k+1]  = sb_q;
  end

  assign vld_o = vld_w[STAGES];
  assign x_o   = x_w[STAGES];
  assign ang_o = ang_w[STAGES];
  assign sb_o  = sb_w[STAGES];

endmodule

>>> rtl/core/cts_gain.sv
// CORDIC gain correction: clamp to non-negative, multiply by 1/K, round half up.
// Two register stages (product, then rounding); uses cts_pkg for the Q24 constant.
`timescale 1ns / 1ps

module cts_gain import cts_pkg::*; #(
  parameter int IN_W  = 23,
  parameter int SB_W  = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic signed [IN_W-1:0] mag_i,
  input  logic [SB_W-1:0]        sb_i,
  output logic                   vld_o,
  output logic [IN_W-2:0]        mag_o,
  output logic [SB_W-1:0]        sb_o
);

  localparam int MAG_W  = IN_W - 1;
  localparam int PROD_W = MAG_W + INV_GAIN_W;

  logic [MAG_W-1:0]  pos;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic [PROD_W:0]   rnd;
  logic [MAG_W-1:0]  mag_d, mag_q;
  logic              vld_a_q, vld_b_q;
  logic [SB_W-1:0]   sb_a_q, sb_b_q;

  // Stage a: negative magnitudes count as zero, then the multiply
  assign pos    = mag_i[IN_W-1] ? '0 : mag_i[MAG_W-1:0];
  assign prod_d = PROD_W'(pos) * PROD_W'(INV_GAIN_Q24);

  // Stage b: round half up and drop the Q24 fraction
  assign rnd   = (PROD_W+1)'(prod_q) + ((PROD_W+1)'(1) << (INV_GAIN_FRAC - 1));
  assign mag_d = rnd[INV_GAIN_FRAC +: MAG_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      sb_a_q <= sb_i;
      mag_q  <= mag_d;
      sb_b_q <= sb_a_q;
    end
  end

  assign vld_o = vld_b_q;
  assign mag_o = mag_q;
  assign sb_o  = sb_b_q;

endmodule

>>> rtl/core/cts_checker.sv
// Port-level checks for the cartesian-to-spherical core, bound to the top level.
// Depends on cartesian_to_spherical for the bind target only.
`timescale 1ns / 1ps

module cts_checker #(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input logic                                           clk_i,
  input logic                                           rst_ni,
  input logic                                           s_tready_i,
  input logic                                           m_tvalid_i,
  input logic                                           m_tready_i,
  input logic [((COORD_WIDTH+2*ANGLE_WIDTH+7)/8)*8-1:0] m_tdata_i
);

  localparam int CW = COORD_WIDTH;
  localparam int AW = ANGLE_WIDTH;

  logic [CW-1:0] radius;
  logic [AW-1:0] polar, azim;

  assign radius = m_tdata_i[CW-1:0];
  assign polar  = m_tdata_i[CW +: AW];
  assign azim   = m_tdata_i[CW+AW +: AW];

  // A stalled output word stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("output word dropped or changed while stalled");

  // Input back-pressure only comes from a full output buffer
  a_bp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_i |-> m_tvalid_i)
    else $error("input stalled with empty output");

  // Polar angle never exceeds pi
  a_polar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (polar <= (AW'(1) << (AW - 1))))
    else $error("polar angle beyond pi");

  // The origin reports both angles as zero
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (radius == '0) |-> (polar == '0) && (azim == '0))
    else $error("nonzero angle at zero radius");

endmodule

bind cartesian_to_spherical cts_checker #(
  .COORD_WIDTH (COORD_WIDTH),
  .ANGLE_WIDTH (ANGLE_WIDTH)
) u_cts_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);
